>>> rtl/point_in_polygon_test_defines.svh
// ----------------------------------------------------------------------------
// Point-in-polygon test: assertion macros
// Shared property macros for the checks at the end of the top-level module.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define PIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never occur outside reset.
`define PIP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test: shared package
// Action codes, sequencer states and the control structs passed between the
// sequencer and the edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    localparam int MIN_VERTICES = 3;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DRAIN = 3'b100
    } pip_state_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } edge_tag_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } edge_result_t;

endpackage

>>> rtl/pip_vertex_mem.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test: vertex memory
// One write port and one read port with registered read data. Each word holds
// the x and y coordinates of one vertex.
// ----------------------------------------------------------------------------
module pip_vertex_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test: edge unit
// Takes one vertex per cycle from the memory, forms the edge with the vertex
// before it, decides the ray crossing exactly by cross multiplication and
// keeps the even-odd parity of the test in progress.
// ----------------------------------------------------------------------------
module pip_edge_unit
    import pip_pkg::*;
#(
    parameter int CW = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  edge_tag_t             tag,
    input  logic [2*CW-1:0]       rd_data,
    input  logic signed [CW-1:0]  px,
    input  logic signed [CW-1:0]  py,
    output edge_result_t          result
);

    localparam int D = CW + 1;
    localparam int P = 2 * D;

    edge_tag_t            tag_reg;
    logic signed [CW-1:0] cur_x;
    logic signed [CW-1:0] cur_y;
    logic signed [CW-1:0] prev_x_reg;
    logic signed [CW-1:0] prev_y_reg;
    logic                 straddle;
    logic signed [D-1:0]  a_next;
    logic signed [D-1:0]  dy_next;
    logic signed [D-1:0]  b_next;
    logic signed [D-1:0]  c_next;

    logic                 s1_cand_reg;
    logic                 s1_last_reg;
    logic signed [D-1:0]  s1_a_reg;
    logic signed [D-1:0]  s1_dy_reg;
    logic signed [D-1:0]  s1_b_reg;
    logic signed [D-1:0]  s1_c_reg;

    logic signed [P-1:0]  lhs_next;
    logic signed [P-1:0]  rhs_next;
    logic                 s2_cand_reg;
    logic                 s2_last_reg;
    logic                 s2_dy_pos_reg;
    logic signed [P-1:0]  s2_lhs_reg;
    logic signed [P-1:0]  s2_rhs_reg;

    logic                 left;
    logic                 parity_reg;
    logic                 parity_next;
    logic                 res_valid_reg;
    logic                 res_hit_reg;

    always_comb
    begin
        cur_x    = rd_data[2*CW-1:CW];
        cur_y    = rd_data[CW-1:0];
        straddle = (cur_y > py) != (prev_y_reg > py);
        a_next   = {px[CW-1], px} - {cur_x[CW-1], cur_x};
        dy_next  = {prev_y_reg[CW-1], prev_y_reg} - {cur_y[CW-1], cur_y};
        b_next   = {prev_x_reg[CW-1], prev_x_reg} - {cur_x[CW-1], cur_x};
        c_next   = {py[CW-1], py} - {cur_y[CW-1], cur_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg     <= '0;
            s1_cand_reg <= 1'b0;
            s1_last_reg <= 1'b0;
        end
        else
        begin
            tag_reg     <= tag;
            s1_cand_reg <= tag_reg.valid && !tag_reg.first && straddle;
            s1_last_reg <= tag_reg.valid && tag_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_reg.valid)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        s1_a_reg  <= a_next;
        s1_dy_reg <= dy_next;
        s1_b_reg  <= b_next;
        s1_c_reg  <= c_next;
    end

    assign lhs_next = s1_a_reg * s1_dy_reg;
    assign rhs_next = s1_b_reg * s1_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_cand_reg <= 1'b0;
            s2_last_reg <= 1'b0;
        end
        else
        begin
            s2_cand_reg <= s1_cand_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_dy_pos_reg <= !s1_dy_reg[D-1];
        s2_lhs_reg    <= lhs_next;
        s2_rhs_reg    <= rhs_next;
    end

    always_comb
    begin
        left        = s2_dy_pos_reg ? (s2_lhs_reg < s2_rhs_reg) : (s2_lhs_reg > s2_rhs_reg);
        parity_next = parity_reg ^ (s2_cand_reg && left);
    end

    // The first vertex of a sweep opens a new transaction and clears the parity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            res_hit_reg   <= 1'b0;
        end
        else
        begin
            if (tag_reg.valid && tag_reg.first)
            begin
                parity_reg <= 1'b0;
            end
            else
            begin
                parity_reg <= parity_next;
            end
            res_valid_reg <= s2_last_reg;
            res_hit_reg   <= parity_next;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.hit   = res_hit_reg;

endmodule

>>> rtl/point_in_polygon_test.sv
// A vertex write leaves busy low.
// A test with vertex_count below 3 answers in the next cycle; otherwise done
// rises once the edge unit has finished a sweep, with n the saturated vertex count.
// Tests do not overlap: a new test waits until busy falls after the drain. The single
// memory read port delivers one vertex per cycle (n + 1 reads per sweep).
// Reset: vertex_count clears to 0; vertex memory contents are undefined.
// ----------------------------------------------------------------------------
// Point-in-polygon test: top level
// Even-odd ray-crossing test of a point against a polygon held in a vertex
// memory, with a sequencer that sweeps the memory for each test transaction.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [$clog2(MAX_VERTICES)-1:0] vertex_index,
    input  logic signed [COORD_WIDTH-1:0]  coord_x,
    input  logic signed [COORD_WIDTH-1:0]  coord_y,
    output logic                           done,
    output logic                           inside_res,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] cfg_data
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = 2 * COORD_WIDTH;

    pip_state_t                    state_reg;
    pip_state_t                    state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              n_eff;
    logic [CNT_W-1:0]              n_reg;
    logic [CNT_W-1:0]              n_next;
    logic [CNT_W-1:0]              rd_cnt_reg;
    logic [CNT_W-1:0]              rd_cnt_next;
    logic [CNT_W-1:0]              rd_addr_wide;
    logic signed [COORD_WIDTH-1:0] px_reg;
    logic signed [COORD_WIDTH-1:0] py_reg;
    logic                          accept;
    logic                          mem_wr;
    logic                          mem_rd;
    logic [AW-1:0]                 rd_addr;
    logic [DW-1:0]                 rd_data;
    edge_tag_t                     tag;
    edge_result_t                  result;
    logic                          short_test;
    logic                          done_reg;
    logic                          done_next;
    logic                          inside_reg;
    logic                          inside_next;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;

    assign n_eff = (count_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_reg;

    assign mem_wr = accept && (action == ACT_WRITE)
                 && ({1'b0, vertex_index} < (AW + 1)'(MAX_VERTICES));
    assign mem_rd = (state_reg == ST_SWEEP);

    assign short_test = accept && (action == ACT_TEST) && (n_eff < CNT_W'(MIN_VERTICES));

    // The sweep reads the last vertex first so that every edge pairs a vertex
    // with the one before it, the closing edge included.
    assign rd_addr_wide = (rd_cnt_reg == '0) ? (n_reg - CNT_W'(1)) : (rd_cnt_reg - CNT_W'(1));
    assign rd_addr      = rd_addr_wide[AW-1:0];

    assign tag.valid = mem_rd;
    assign tag.first = (rd_cnt_reg == '0);
    assign tag.last  = (rd_cnt_reg == n_reg);

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        n_next      = n_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACT_TEST) && !short_test)
                begin
                    state_next  = ST_SWEEP;
                    rd_cnt_next = '0;
                    n_next      = n_eff;
                end
            end
            ST_SWEEP:
            begin
                if (rd_cnt_reg == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (result.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done_next   = result.valid || short_test;
        inside_next = result.valid && result.hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            n_reg      <= '0;
            rd_cnt_reg <= '0;
            done_reg   <= 1'b0;
            inside_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            rd_cnt_reg <= rd_cnt_next;
            done_reg   <= done_next;
            inside_reg <= inside_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_TEST))
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;

    pip_vertex_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (vertex_index),
        .wr_data ({coord_x, coord_y}),
        .rd_en   (mem_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pip_edge_unit #(
        .CW (COORD_WIDTH)
    ) u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag     (tag),
        .rd_data (rd_data),
        .px      (px_reg),
        .py      (py_reg),
        .result  (result)
    );

    `PIP_ASSERT_NEVER(a_no_wr_during_sweep, mem_wr && mem_rd, "vertex write during a sweep")
    `PIP_ASSERT_IMP(a_sweep_bound, state_reg == ST_SWEEP, rd_cnt_reg <= n_reg, "sweep overrun")
    `PIP_ASSERT_IMP(a_result_in_drain, result.valid, state_reg == ST_DRAIN, "stray edge result")
    `PIP_ASSERT_IMP(a_short_is_outside, $past(short_test), done && !inside_res, "short test not outside")

endmodule

>>> tb/polygon_membership_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: transaction checker
// Watches the command, configuration and result ports of the block. It keeps
// its own copy of the vertex store and of the vertex count, predicts the
// inside flag of every test transaction and compares it with the result.
// ----------------------------------------------------------------------------
module polygon_membership_checker
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              action,
    input  logic [$clog2(MAX_VERTICES)-1:0]   vertex_index,
    input  logic signed [COORD_WIDTH-1:0]     coord_x,
    input  logic signed [COORD_WIDTH-1:0]     coord_y,
    input  logic                              done,
    input  logic                              inside_res,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [$clog2(MAX_VERTICES+1)-1:0] cfg_data,
    output int                                fail_count,
    output int                                pending_results,
    output int                                tests_seen,
    output int                                inside_seen,
    output int                                writes_seen
);

    typedef struct {
        bit hit;
        int px;
        int py;
        int count;
        int seq;
    } inside_guess_t;

    logic signed [COORD_WIDTH-1:0] vx_copy [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vy_copy [MAX_VERTICES];
    int            vcount_copy;
    inside_guess_t inside_expected [$];
    inside_guess_t head;
    int            failures;
    int            n_tests;
    int            n_inside;
    int            n_writes;

    function automatic bit point_inside_polygon(
        input logic signed [COORD_WIDTH-1:0] px,
        input logic signed [COORD_WIDTH-1:0] py
    );
        longint sx, sy, x1, y1, x2, y2, dy, lhs, rhs;
        int     n, i, j;
        bit     parity;
        n      = (vcount_copy > MAX_VERTICES) ? MAX_VERTICES : vcount_copy;
        parity = 1'b0;
        if (n < MIN_VERTICES)
            return 1'b0;
        sx = px;
        sy = py;
        j  = n - 1;
        for (i = 0; i < n; i++)
        begin
            x1 = vx_copy[i];
            y1 = vy_copy[i];
            x2 = vx_copy[j];
            y2 = vy_copy[j];
            if ((y1 > sy) != (y2 > sy))
            begin
                dy  = y2 - y1;
                lhs = (sx - x1) * dy;
                rhs = (x2 - x1) * (sy - y1);
                if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                    parity = !parity;
            end
            j = i;
        end
        return parity;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_expected.delete();
            vcount_copy     = 0;
            failures        = 0;
            n_tests         = 0;
            n_inside        = 0;
            n_writes        = 0;
            fail_count      <= 0;
            pending_results <= 0;
            tests_seen      <= 0;
            inside_seen     <= 0;
            writes_seen     <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                vcount_copy = cfg_data;
            if (start && !busy)
            begin
                if (action == ACT_WRITE)
                begin
                    vx_copy[vertex_index] = coord_x;
                    vy_copy[vertex_index] = coord_y;
                    n_writes++;
                end
                else
                begin
                    head.hit   = point_inside_polygon(coord_x, coord_y);
                    head.px    = coord_x;
                    head.py    = coord_y;
                    head.count = vcount_copy;
                    head.seq   = n_tests;
                    inside_expected = {inside_expected, head};
                    n_tests++;
                end
            end
            if (done)
            begin
                if (inside_res)
                    n_inside++;
                if (inside_expected.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%t: result inside_res=%0b arrived with no test pending",
                                 $realtime, inside_res);
                end
                else
                begin
                    head = inside_expected.pop_front();
                    if (head.hit !== inside_res)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("%t: test %0d (%0d, %0d) n=%0d: expected %0b, got %0b",
                                     $realtime, head.seq, head.px, head.py, head.count,
                                     head.hit, inside_res);
                    end
                end
            end
            fail_count      <= failures;
            pending_results <= inside_expected.size();
            tests_seen      <= n_tests;
            inside_seen     <= n_inside;
            writes_seen     <= n_writes;
        end
    end

endmodule

>>> tb/point_in_polygon_test_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon test: testbench top
// Drives vertex writes, point tests and vertex-count settings into the block,
// first a directed set of corner cases, then random polygons and points with
// random idle gaps, and reports the verdict from the transaction checker.
// ----------------------------------------------------------------------------
module point_in_polygon_test_test
    import pip_pkg::*;
();

    localparam int     MAX_VERTICES  = 16;
    localparam int     COORD_WIDTH   = 24;
    localparam int     ITEM_TARGET   = 1450;
    localparam int     SETTLE_CYCLES = MAX_VERTICES + 10;
    localparam longint COORD_LO      = -(longint'(1) << (COORD_WIDTH - 1));
    localparam longint COORD_HI      = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic                              action;
    logic [$clog2(MAX_VERTICES)-1:0]   vertex_index;
    logic signed [COORD_WIDTH-1:0]     coord_x;
    logic signed [COORD_WIDTH-1:0]     coord_y;
    logic                              done;
    logic                              inside_res;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [$clog2(MAX_VERTICES+1)-1:0] cfg_data;

    int fail_count;
    int pending_results;
    int tests_seen;
    int inside_seen;
    int writes_seen;

    int     items_sent;
    int     settings_used;
    bit     quiet_phase;
    longint ctr_x;
    longint ctr_y;
    longint spread;
    int     poly_n;
    logic signed [COORD_WIDTH-1:0] poly_x [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] poly_y [MAX_VERTICES];

    always #4 clk = ~clk;

    point_in_polygon_test #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .vertex_index (vertex_index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .done         (done),
        .inside_res   (inside_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    polygon_membership_checker #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) membership_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .vertex_index    (vertex_index),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .done            (done),
        .inside_res      (inside_res),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .tests_seen      (tests_seen),
        .inside_seen     (inside_seen),
        .writes_seen     (writes_seen)
    );

    function automatic logic signed [COORD_WIDTH-1:0] coord_near(
        input longint center,
        input longint reach
    );
        longint v;
        v = center - reach + longint'($urandom_range(0, 32'(2 * reach)));
        if (v < COORD_LO)
            v = COORD_LO;
        else if (v > COORD_HI)
            v = COORD_HI;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] coord_edge_or_near(input longint center);
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0)
            return COORD_MIN;
        else if (pick == 1)
            return COORD_MAX;
        return coord_near(center, spread);
    endfunction

    task automatic pause_sender();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 55)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(
        input logic                          act,
        input int                            slot,
        input logic signed [COORD_WIDTH-1:0] x,
        input logic signed [COORD_WIDTH-1:0] y
    );
        start        <= 1'b1;
        action       <= act;
        vertex_index <= slot[$clog2(MAX_VERTICES)-1:0];
        coord_x      <= x;
        coord_y      <= y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        if (act == ACT_WRITE && slot < MAX_VERTICES)
        begin
            poly_x[slot] = x;
            poly_y[slot] = y;
        end
        pause_sender();
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic load_count(input int count);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= count[$clog2(MAX_VERTICES+1)-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        poly_n = (count > MAX_VERTICES) ? MAX_VERTICES : count;
        settings_used++;
    endtask

    task automatic test_random_point();
        int mode;
        int k;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        mode = $urandom_range(0, 9);
        k    = (poly_n > 0) ? $urandom_range(0, poly_n - 1) : 0;
        if (mode < 4)
        begin
            x = coord_near(ctr_x, spread);
            y = coord_near(ctr_y, spread);
        end
        else if (mode < 6)
        begin
            x = poly_x[k];
            y = poly_y[k];
        end
        else if (mode < 8)
        begin
            x = coord_near(ctr_x, spread);
            y = poly_y[k];
        end
        else if (mode == 8)
        begin
            x = coord_edge_or_near(ctr_x);
            y = coord_edge_or_near(ctr_y);
        end
        else
        begin
            x = coord_near(0, COORD_HI + 1);
            y = coord_near(0, COORD_HI + 1);
        end
        issue(ACT_TEST, $urandom_range(0, MAX_VERTICES - 1), x, y);
    endtask

    initial
    begin
        int phase;
        int count;
        int kind;
        int batch;
        int k;
        rst_n        = 1'b0;
        start        = 1'b0;
        action       = ACT_WRITE;
        vertex_index = '0;
        coord_x      = '0;
        coord_y      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        items_sent    = 0;
        settings_used = 0;
        quiet_phase   = 1'b0;
        poly_n        = 0;
        ctr_x         = 0;
        ctr_y         = 0;
        spread        = COORD_HI + 1;
        for (k = 0; k < MAX_VERTICES; k++)
        begin
            poly_x[k] = '0;
            poly_y[k] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty polygon, too few vertices, extreme square, triangle.
        issue(ACT_TEST, 0, 0, 0);
        issue(ACT_WRITE, 0, COORD_MIN, COORD_MIN);
        issue(ACT_WRITE, 1, COORD_MAX, COORD_MIN);
        issue(ACT_WRITE, 2, COORD_MAX, COORD_MAX);
        issue(ACT_WRITE, 3, COORD_MIN, COORD_MAX);
        load_count(1);
        issue(ACT_TEST, 0, 0, 0);
        load_count(2);
        issue(ACT_TEST, 0, 0, 0);
        load_count(4);
        issue(ACT_TEST, 0, 0, 0);
        issue(ACT_TEST, 15, -1, -1);
        issue(ACT_TEST, 0, COORD_MIN, COORD_MIN);
        issue(ACT_TEST, 0, COORD_MAX, COORD_MAX);
        issue(ACT_TEST, 0, COORD_MIN, 0);
        issue(ACT_TEST, 0, COORD_MAX, 0);
        issue(ACT_TEST, 0, 0, COORD_MIN);
        issue(ACT_TEST, 0, 0, COORD_MAX);
        issue(ACT_TEST, 0, COORD_MAX - 1, COORD_MAX - 1);
        load_count(3);
        issue(ACT_TEST, 0, 0, 0);
        issue(ACT_TEST, 0, 1, -1);
        issue(ACT_TEST, 0, -1, 1);
        issue(ACT_TEST, 0, COORD_MAX, 0);

        // Random polygons, one vertex-count setting per phase.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase <= MAX_VERTICES)
                count = MAX_VERTICES - phase;
            else if (phase == MAX_VERTICES + 1)
                count = 31;
            else if ($urandom_range(0, 9) == 0)
                count = $urandom_range(MAX_VERTICES + 1, 31);
            else if ($urandom_range(0, 9) == 0)
                count = $urandom_range(0, MIN_VERTICES - 1);
            else
                count = $urandom_range(MIN_VERTICES, MAX_VERTICES);
            load_count(count);
            quiet_phase = ($urandom_range(0, 4) == 0);
            kind        = $urandom_range(0, 3);
            if (kind == 0)
            begin
                ctr_x  = 0;
                ctr_y  = 0;
                spread = COORD_HI + 1;
            end
            else if (kind == 1)
            begin
                ctr_x  = coord_near(0, COORD_HI + 1);
                ctr_y  = coord_near(0, COORD_HI + 1);
                spread = $urandom_range(2, 12);
            end
            else if (kind == 2)
            begin
                ctr_x  = coord_near(0, COORD_HI + 1);
                ctr_y  = coord_near(0, COORD_HI + 1);
                spread = longint'(1) << $urandom_range(6, 20);
            end
            else
            begin
                ctr_x  = $urandom_range(0, 1) ? COORD_LO : COORD_HI;
                ctr_y  = $urandom_range(0, 1) ? COORD_LO : COORD_HI;
                spread = longint'(1) << $urandom_range(4, COORD_WIDTH - 1);
            end
            for (k = 0; k < poly_n; k++)
                issue(ACT_WRITE, k, coord_near(ctr_x, spread), coord_near(ctr_y, spread));
            batch = $urandom_range(30, 60);
            for (k = 0; k < batch; k++)
            begin
                if ($urandom_range(0, 99) < 12)
                    issue(ACT_WRITE, $urandom_range(0, MAX_VERTICES - 1),
                          coord_near(ctr_x, spread), coord_near(ctr_y, spread));
                else
                    test_random_point();
            end
            phase++;
        end

        drain_results();
        $display("Covered %0d vertex writes and %0d point tests (%0d inside),",
                 writes_seen, tests_seen, inside_seen);
        $display("over %0d vertex-count settings including 0, 16 and saturated values.",
                 settings_used);
        if (fail_count == 0 && pending_results == 0)
            $display("point_in_polygon_test_test: done, clean");
        else
            $display("point_in_polygon_test_test: done, errors");
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("point_in_polygon_test_test: done, errors");
        $finish;
    end

endmodule
